// ===== sv/mte_pkg.sv =====
`timescale 1ns / 1ps

package mte_pkg;

    // token kinds
    localparam logic [3:0] KIND_NULL     = 4'd0;
    localparam logic [3:0] KIND_BOOL     = 4'd1;
    localparam logic [3:0] KIND_DOUBLE   = 4'd2;
    localparam logic [3:0] KIND_SIGNED   = 4'd3;
    localparam logic [3:0] KIND_UNSIGNED = 4'd4;
    localparam logic [3:0] KIND_STR      = 4'd5;
    localparam logic [3:0] KIND_BIN      = 4'd6;
    localparam logic [3:0] KIND_ARRAY    = 4'd7;
    localparam logic [3:0] KIND_MAP      = 4'd8;
    localparam logic [3:0] KIND_PAYLOAD  = 4'd9;

    // messagepack lead bytes
    localparam logic [7:0] MP_NIL      = 8'hC0;
    localparam logic [7:0] MP_FALSE    = 8'hC2;
    localparam logic [7:0] MP_TRUE     = 8'hC3;
    localparam logic [7:0] MP_BIN8     = 8'hC4;
    localparam logic [7:0] MP_BIN16    = 8'hC5;
    localparam logic [7:0] MP_BIN32    = 8'hC6;
    localparam logic [7:0] MP_FLOAT64  = 8'hCB;
    localparam logic [7:0] MP_UINT8    = 8'hCC;
    localparam logic [7:0] MP_UINT16   = 8'hCD;
    localparam logic [7:0] MP_UINT32   = 8'hCE;
    localparam logic [7:0] MP_UINT64   = 8'hCF;
    localparam logic [7:0] MP_INT8     = 8'hD0;
    localparam logic [7:0] MP_INT16    = 8'hD1;
    localparam logic [7:0] MP_INT32    = 8'hD2;
    localparam logic [7:0] MP_INT64    = 8'hD3;
    localparam logic [7:0] MP_STR8     = 8'hD9;
    localparam logic [7:0] MP_STR16    = 8'hDA;
    localparam logic [7:0] MP_STR32    = 8'hDB;
    localparam logic [7:0] MP_ARRAY16  = 8'hDC;
    localparam logic [7:0] MP_ARRAY32  = 8'hDD;
    localparam logic [7:0] MP_MAP16    = 8'hDE;
    localparam logic [7:0] MP_MAP32    = 8'hDF;
    localparam logic [2:0] MP_FIXSTR   = 3'b101;
    localparam logic [3:0] MP_FIXARRAY = 4'b1001;
    localparam logic [3:0] MP_FIXMAP   = 4'b1000;

    // most data bytes behind one lead byte
    localparam int MAX_DATA_BYTES = 8;

    typedef logic [3:0] cnt_t;

    // range flags worked out in the first stage
    typedef struct packed {
        logic kind_ok;
        logic neg;
        logic u_fix;
        logic u_le8;
        logic u_le16;
        logic u_le32;
        logic n_fix;
        logic n_ge8;
        logic n_ge16;
        logic n_ge32;
        logic l_le31;
        logic l_le15;
    } flags_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value;
        flags_t      flags;
    } class_t;

    // lead byte plus left-aligned data bytes
    typedef struct packed {
        logic [7:0]  hdr;
        logic [63:0] data;
        cnt_t        cnt;
    } frame_t;

endpackage

// ===== sv/mte_classify.sv =====
`timescale 1ns / 1ps

module mte_classify
    import mte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  func,
    input  logic [63:0] token_value,
    output logic        m_valid,
    input  logic        m_ready,
    output class_t      m_data
);

    logic   valid_reg;
    logic   valid_next;
    class_t data_reg;
    class_t data_next;

    assign s_ready = !valid_reg || m_ready;

    always_comb
    begin
        data_next.kind           = func;
        data_next.value          = token_value;
        data_next.flags.kind_ok  = (func <= KIND_PAYLOAD);
        data_next.flags.neg      = token_value[63];
        data_next.flags.u_fix    = (token_value[63:7] == '0);
        data_next.flags.u_le8    = (token_value[63:8] == '0);
        data_next.flags.u_le16   = (token_value[63:16] == '0);
        data_next.flags.u_le32   = (token_value[63:32] == '0);
        data_next.flags.n_fix    = &token_value[63:5];
        data_next.flags.n_ge8    = &token_value[63:7];
        data_next.flags.n_ge16   = &token_value[63:15];
        data_next.flags.n_ge32   = &token_value[63:31];
        data_next.flags.l_le31   = (token_value[63:5] == '0);
        data_next.flags.l_le15   = (token_value[63:4] == '0);
        valid_next = s_ready ? s_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== sv/mte_header.sv =====
`timescale 1ns / 1ps

module mte_header
    import mte_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   s_valid,
    output logic   s_ready,
    input  class_t s_data,
    output logic   m_valid,
    input  logic   m_ready,
    output frame_t m_data
);

    logic   valid_reg;
    logic   valid_next;
    frame_t data_reg;
    frame_t data_next;
    logic [7:0]  hdr;
    cnt_t        cnt;
    logic [63:0] v;
    flags_t      f;

    assign s_ready = !valid_reg || m_ready;
    assign v = s_data.value;
    assign f = s_data.flags;

    always_comb
    begin
        hdr = MP_NIL;
        cnt = 4'd0;
        case (s_data.kind)
            KIND_NULL:
            begin
                hdr = MP_NIL;
            end
            KIND_BOOL:
            begin
                hdr = v[0] ? MP_TRUE : MP_FALSE;
            end
            KIND_DOUBLE:
            begin
                hdr = MP_FLOAT64;
                cnt = 4'd8;
            end
            KIND_SIGNED, KIND_UNSIGNED:
            begin
                if (s_data.kind == KIND_SIGNED && f.neg)
                begin
                    if (f.n_fix)       begin hdr = v[7:0];  cnt = 4'd0; end
                    else if (f.n_ge8)  begin hdr = MP_INT8;  cnt = 4'd1; end
                    else if (f.n_ge16) begin hdr = MP_INT16; cnt = 4'd2; end
                    else if (f.n_ge32) begin hdr = MP_INT32; cnt = 4'd4; end
                    else               begin hdr = MP_INT64; cnt = 4'd8; end
                end
                else
                begin
                    if (f.u_fix)       begin hdr = v[7:0];    cnt = 4'd0; end
                    else if (f.u_le8)  begin hdr = MP_UINT8;  cnt = 4'd1; end
                    else if (f.u_le16) begin hdr = MP_UINT16; cnt = 4'd2; end
                    else if (f.u_le32) begin hdr = MP_UINT32; cnt = 4'd4; end
                    else               begin hdr = MP_UINT64; cnt = 4'd8; end
                end
            end
            KIND_STR:
            begin
                if (f.l_le31)      begin hdr = {MP_FIXSTR, v[4:0]}; cnt = 4'd0; end
                else if (f.u_le8)  begin hdr = MP_STR8;  cnt = 4'd1; end
                else if (f.u_le16) begin hdr = MP_STR16; cnt = 4'd2; end
                else               begin hdr = MP_STR32; cnt = 4'd4; end
            end
            KIND_BIN:
            begin
                if (f.u_le8)       begin hdr = MP_BIN8;  cnt = 4'd1; end
                else if (f.u_le16) begin hdr = MP_BIN16; cnt = 4'd2; end
                else               begin hdr = MP_BIN32; cnt = 4'd4; end
            end
            KIND_ARRAY:
            begin
                if (f.l_le15)      begin hdr = {MP_FIXARRAY, v[3:0]}; cnt = 4'd0; end
                else if (f.u_le16) begin hdr = MP_ARRAY16; cnt = 4'd2; end
                else               begin hdr = MP_ARRAY32; cnt = 4'd4; end
            end
            KIND_MAP:
            begin
                if (f.l_le15)      begin hdr = {MP_FIXMAP, v[3:0]}; cnt = 4'd0; end
                else if (f.u_le16) begin hdr = MP_MAP16; cnt = 4'd2; end
                else               begin hdr = MP_MAP32; cnt = 4'd4; end
            end
            KIND_PAYLOAD:
            begin
                hdr = v[7:0];
            end
            default:
            begin
                hdr = MP_NIL;
                cnt = 4'd0;
            end
        endcase
    end

    // left-align the data field so the first byte sits on top
    always_comb
    begin
        data_next.hdr = hdr;
        data_next.cnt = cnt;
        case (cnt)
            4'd1:    data_next.data = {v[7:0], 56'd0};
            4'd2:    data_next.data = {v[15:0], 48'd0};
            4'd4:    data_next.data = {v[31:0], 32'd0};
            4'd8:    data_next.data = v;
            default: data_next.data = '0;
        endcase
        // unused kinds produce no bytes and are dropped here
        valid_next = s_ready ? (s_valid && f.kind_ok) : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== sv/mte_serializer.sv =====
`timescale 1ns / 1ps

module mte_serializer
    import mte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_valid,
    output logic       s_ready,
    input  frame_t     s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_byte,
    output logic       m_last
);

    logic        valid_reg;
    logic        valid_next;
    logic        sent_reg;
    logic        sent_next;
    cnt_t        cnt_reg;
    cnt_t        cnt_next;
    logic [7:0]  hdr_reg;
    logic [7:0]  hdr_next;
    logic [63:0] data_reg;
    logic [63:0] data_next;
    logic        last;
    logic        take;

    assign last    = sent_reg ? (cnt_reg == 4'd1) : (cnt_reg == 4'd0);
    assign s_ready = !valid_reg || (m_ready && last);
    assign take    = s_ready && s_valid;

    always_comb
    begin
        valid_next = valid_reg;
        sent_next  = sent_reg;
        cnt_next   = cnt_reg;
        hdr_next   = hdr_reg;
        data_next  = data_reg;
        if (take)
        begin
            valid_next = 1'b1;
            sent_next  = 1'b0;
            cnt_next   = s_data.cnt;
            hdr_next   = s_data.hdr;
            data_next  = s_data.data;
        end
        else if (valid_reg && m_ready)
        begin
            if (last)
            begin
                valid_next = 1'b0;
            end
            else if (!sent_reg)
            begin
                sent_next = 1'b1;
            end
            else
            begin
                cnt_next  = cnt_reg - 4'd1;
                data_next = {data_reg[55:0], 8'd0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sent_reg  <= 1'b0;
            cnt_reg   <= 4'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            sent_reg  <= sent_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg  <= hdr_next;
        data_reg <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_byte  = sent_reg ? data_reg[63:56] : hdr_reg;
    assign m_last  = last;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (cnt_reg <= 4'(MAX_DATA_BYTES)))
        else $error("byte count out of range");

    a_more_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && m_ready && !last) |=> valid_reg)
        else $error("item dropped before its last byte");

    a_hdr_first: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && m_ready && !last && !sent_reg) |=> (sent_reg && cnt_reg != 4'd0))
        else $error("lead byte not followed by data");

    a_load_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        s_ready |-> (!valid_reg || last))
        else $error("new item taken mid-token");

endmodule

// ===== sv/msgpack_token_encoder.sv =====
`timescale 1ns / 1ps

// messagepack token encoder: takes one token item per cycle when in_ready is
// high (kind in func, value in token_value) and sends its messagepack bytes,
// one item per byte, with last_byte high on the final byte of each token. a
// token leaves the output as 1 byte (null, bool, fixint, fix headers, payload)
// up to 9 bytes (64-bit integers, double); the byte serializer at the output
// sets the rate, and a stream of payload bytes flows at one per cycle while
// out_ready is high. first byte valid once the token has passed three register
// stages (classify, header, serializer), the first one loaded at the input
// accept edge. token kinds 10 to 15 produce no bytes and are silently dropped.
// nesting is carried only by token order; no depth check is done.

module msgpack_token_encoder
    import mte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  func,
    input  logic [63:0] token_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_byte
);

    // stage 1 to stage 2: token with range flags
    logic   cls_valid;
    logic   cls_ready;
    class_t cls_data;

    // stage 2 to stage 3: lead byte and aligned data bytes
    logic   frm_valid;
    logic   frm_ready;
    frame_t frm_data;

    // stage 1: range compares on the raw value
    mte_classify u_classify (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_valid     (in_valid),
        .s_ready     (in_ready),
        .func        (func),
        .token_value (token_value),
        .m_valid     (cls_valid),
        .m_ready     (cls_ready),
        .m_data      (cls_data)
    );

    // stage 2: pick the shortest form, lead byte and data byte count
    mte_header u_header (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (cls_valid),
        .s_ready (cls_ready),
        .s_data  (cls_data),
        .m_valid (frm_valid),
        .m_ready (frm_ready),
        .m_data  (frm_data)
    );

    // stage 3: byte serializer doubling as the output register
    mte_serializer u_serializer (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (frm_valid),
        .s_ready (frm_ready),
        .s_data  (frm_data),
        .m_valid (out_valid),
        .m_ready (out_ready),
        .m_byte  (out_byte),
        .m_last  (last_byte)
    );

endmodule
